[rtl/yuv420_block_to_rgba_assert.svh]
// assertion macros for the yuv420 block to rgba converter
// expects aclk and aresetn in the scope of each use
`ifndef YUV420_BLOCK_TO_RGBA_ASSERT_SVH
`define YUV420_BLOCK_TO_RGBA_ASSERT_SVH

// same-cycle implication, quiet during reset
`define Y2R_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("y2r assertion failed");

// next-cycle implication, quiet during reset
`define Y2R_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("y2r assertion failed");

`endif

[rtl/y2r_pkg.sv]
// types and constants for the yuv420 block to rgba converter
// no dependencies
package y2r_pkg;

    localparam longint COEF_LUMA_MILLI    = 1164;
    localparam longint COEF_RED_V_MILLI   = 1596;
    localparam longint COEF_GREEN_U_MILLI = 391;
    localparam longint COEF_GREEN_V_MILLI = 813;
    localparam longint COEF_BLUE_U_MILLI  = 2018;
    localparam longint LUMA_OFFSET        = 16;
    localparam longint CHROMA_OFFSET      = 128;
    localparam logic [7:0] CHANNEL_MAX    = 8'd255;
    localparam logic [1:0] LAST_PIXEL     = 2'd3;

    typedef struct packed {
        logic [7:0] luma_top_left;
        logic [7:0] luma_top_right;
        logic [7:0] luma_bottom_left;
        logic [7:0] luma_bottom_right;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
    } y2r_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       row_in_block;
        logic       column_in_block;
        logic       last_of_block;
    } y2r_out_t;

    // scaled coefficient times offset, rounded toward zero, elaboration only
    function automatic longint coef_term(longint milli, longint k, int fb);
        longint scaled;
        scaled = milli * (64'sd1 <<< fb) + 64'sd500;
        return (k * scaled) / 64'sd1000;
    endfunction

endpackage

[rtl/yuv420_block_to_rgba.sv]
// yuv420 2x2 block to four rgba pixels, bt601 fixed-point coefficients
// depends on y2r_pkg and yuv420_block_to_rgba_assert.svh
//
// One 2x2 block is taken at a time and gives four pixels in raster order
// (top-left, top-right, bottom-left, bottom-right), one per cycle on the result
// port unless the result side stalls, which sets the block rate. The next block is
// taken as the last pixel of the current one issues. A block register feeds one
// pixel at a time into a three-stage pipeline (coefficient table lookup, channel
// sums, floor shift and clamp into the output register). Stalls on the result side
// back up the pipeline without losing or repeating a pixel. Alpha is always 255.
`include "yuv420_block_to_rgba_assert.svh"

module yuv420_block_to_rgba import y2r_pkg::*; #(
    parameter int FRACTION_BITS = 13
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  y2r_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output y2r_out_t m_data
);

    localparam int TERM_W = FRACTION_BITS + 10;
    localparam int SUM_W  = FRACTION_BITS + 11;
    localparam int CH_W   = SUM_W - FRACTION_BITS;

    // constant coefficient tables indexed by the raw byte
    logic signed [TERM_W-1:0] luma_tab    [256];
    logic signed [TERM_W-1:0] red_v_tab   [256];
    logic signed [TERM_W-1:0] green_u_tab [256];
    logic signed [TERM_W-1:0] green_v_tab [256];
    logic signed [TERM_W-1:0] blue_u_tab  [256];

    for (genvar i = 0; i < 256; i++) begin : g_tab
        localparam longint LumaT =
            coef_term(COEF_LUMA_MILLI, longint'(i) - LUMA_OFFSET, FRACTION_BITS);
        localparam longint RedVT =
            coef_term(COEF_RED_V_MILLI, longint'(i) - CHROMA_OFFSET, FRACTION_BITS);
        localparam longint GreenUT =
            coef_term(COEF_GREEN_U_MILLI, longint'(i) - CHROMA_OFFSET, FRACTION_BITS);
        localparam longint GreenVT =
            coef_term(COEF_GREEN_V_MILLI, longint'(i) - CHROMA_OFFSET, FRACTION_BITS);
        localparam longint BlueUT =
            coef_term(COEF_BLUE_U_MILLI, longint'(i) - CHROMA_OFFSET, FRACTION_BITS);
        assign luma_tab[i]    = TERM_W'(LumaT);
        assign red_v_tab[i]   = TERM_W'(RedVT);
        assign green_u_tab[i] = TERM_W'(GreenUT);
        assign green_v_tab[i] = TERM_W'(GreenVT);
        assign blue_u_tab[i]  = TERM_W'(BlueUT);
    end

    // block register and pixel sequencing
    logic     blk_valid_reg;
    logic [1:0] idx_reg;
    y2r_in_t  blk_reg;

    // stage 1: table terms
    logic                     v1_reg;
    logic [1:0]               idx1_reg;
    logic signed [TERM_W-1:0] ly_reg, ra_reg, gu_reg, gv_reg, ba_reg;

    // stage 2: channel sums
    logic                    v2_reg;
    logic [1:0]              idx2_reg;
    logic signed [SUM_W-1:0] r_sum_reg, g_sum_reg, b_sum_reg;

    // stage 3: output register
    logic     m_valid_reg;
    y2r_out_t m_data_reg;

    logic en1, en2, en3, pix_fire;
    logic [7:0] luma_sel;
    logic signed [CH_W-1:0] r_ch, g_ch, b_ch;

    assign en3      = !m_valid_reg || m_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign pix_fire = blk_valid_reg && en1;
    assign s_ready  = !blk_valid_reg || (idx_reg == LAST_PIXEL && en1);

    always_comb begin
        case (idx_reg)
            2'd0:    luma_sel = blk_reg.luma_top_left;
            2'd1:    luma_sel = blk_reg.luma_top_right;
            2'd2:    luma_sel = blk_reg.luma_bottom_left;
            default: luma_sel = blk_reg.luma_bottom_right;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else if (s_valid && s_ready) begin
            blk_valid_reg <= 1'b1;
            idx_reg       <= 2'd0;
            blk_reg       <= s_data;
        end else if (pix_fire) begin
            idx_reg <= idx_reg + 2'd1;
            if (idx_reg == LAST_PIXEL) begin
                blk_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg   <= blk_valid_reg;
            idx1_reg <= idx_reg;
            ly_reg   <= luma_tab[luma_sel];
            ra_reg   <= red_v_tab[blk_reg.chroma_red];
            gu_reg   <= green_u_tab[blk_reg.chroma_blue];
            gv_reg   <= green_v_tab[blk_reg.chroma_red];
            ba_reg   <= blue_u_tab[blk_reg.chroma_blue];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg    <= v1_reg;
            idx2_reg  <= idx1_reg;
            r_sum_reg <= SUM_W'(ly_reg) + SUM_W'(ra_reg);
            g_sum_reg <= SUM_W'(ly_reg) - SUM_W'(gu_reg) - SUM_W'(gv_reg);
            b_sum_reg <= SUM_W'(ly_reg) + SUM_W'(ba_reg);
        end
    end

    // dropping the fraction bits is a floor shift
    assign r_ch = r_sum_reg[SUM_W-1:FRACTION_BITS];
    assign g_ch = g_sum_reg[SUM_W-1:FRACTION_BITS];
    assign b_ch = b_sum_reg[SUM_W-1:FRACTION_BITS];

    function automatic logic [7:0] clamp8(logic signed [CH_W-1:0] c);
        if (c[CH_W-1]) begin
            return 8'd0;
        end else if (|c[CH_W-2:8]) begin
            return CHANNEL_MAX;
        end
        return c[7:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en3) begin
            m_valid_reg                <= v2_reg;
            m_data_reg.red             <= clamp8(r_ch);
            m_data_reg.green           <= clamp8(g_ch);
            m_data_reg.blue            <= clamp8(b_ch);
            m_data_reg.alpha           <= CHANNEL_MAX;
            m_data_reg.row_in_block    <= idx2_reg[1];
            m_data_reg.column_in_block <= idx2_reg[0];
            m_data_reg.last_of_block   <= (idx2_reg == LAST_PIXEL);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `Y2R_ASSERT_NEXT(a_load_starts_block, s_valid && s_ready,
        blk_valid_reg && idx_reg == 2'd0)
    `Y2R_ASSERT_NEXT(a_stage2_holds, v2_reg && !en2,
        v2_reg && $stable(r_sum_reg) && $stable(g_sum_reg) && $stable(idx2_reg))
    `Y2R_ASSERT_NOW(a_last_is_bottom_right, m_valid && m_data.last_of_block,
        m_data.row_in_block && m_data.column_in_block)
    `Y2R_ASSERT_NOW(a_alpha_opaque, m_valid, m_data.alpha == CHANNEL_MAX)

endmodule
